[hw/rtl/pre_pkg.sv]
// Shared types and codes for the page replacement engine.
package pre_pkg;

	typedef enum logic [2:0] {
		ST_HIT   = 3'd0,
		ST_POOL  = 3'd1,
		ST_EVICT = 3'd2,
		ST_NONE  = 3'd3,
		ST_ADDED = 3'd4,
		ST_FULL  = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		POL_FIFO = 2'd0,
		POL_LRU  = 2'd1,
		POL_LFU  = 2'd2,
		POL_RSVD = 2'd3
	} policy_t;

	localparam logic [0:0] REG_POLICY = 1'b0;
	localparam logic [0:0] REG_PAGES  = 1'b1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_LOOK,
		S_SCAN,
		S_SCAN_LAST,
		S_EVICT,
		S_DONE
	} state_t;

	// One page table row, kept in a single memory word.
	typedef struct packed {
		logic [9:0]  frame;
		logic [31:0] arrival;
		logic [31:0] last_access;
		logic [15:0] refs;
	} entry_t;

endpackage

[hw/rtl/pre_victim_cmp.sv]
// Victim compare: does a candidate row beat the current best under the policy.
module pre_victim_cmp (
	input  pre_pkg::policy_t policy,
	input  pre_pkg::entry_t  cand,
	input  pre_pkg::entry_t  best,
	output logic             better
);

	always_comb begin
		case (policy)
			pre_pkg::POL_LRU: better = cand.last_access < best.last_access;
			pre_pkg::POL_LFU: better = (cand.refs < best.refs) ||
				((cand.refs == best.refs) && (cand.arrival < best.arrival));
			default: better = cand.arrival < best.arrival;
		endcase
	end

endmodule

[hw/rtl/page_replacement_engine.sv]
// Top level of the page replacement engine: page table, free pool, victim scan.
//
//  channel  direction  handshake            payload
//  in       input      in_valid / in_stall  mode page timestamp new_frame
//  out      output     out_valid / out_stall status frame victim_page fault_total
//  cfg      input      cfg_we               cfg_index cfg_data
//
// A hit, pool item or pool fault passes through table read, update and result.
// A fault with an empty pool scans the table once through its read port, rows 0 to
// min(pages_in_use, PAGES) - 1, and skips the eviction step when no victim is found.
// Reset clears valid bits, pool count and fault total at once; no clearing pass.
// One item at a time; in_stall is high until the result has been taken.
module page_replacement_engine #(
	parameter int PAGES      = 64,
	parameter int POOL_DEPTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [0:0]  mode,
	input  logic [5:0]  page,
	input  logic [31:0] timestamp,
	input  logic [9:0]  new_frame,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic [9:0]  frame,
	output logic [5:0]  victim_page,
	output logic [31:0] fault_total,
	input  logic        cfg_we,
	input  logic [0:0]  cfg_index,
	input  logic [6:0]  cfg_data
);

	localparam int PW = (PAGES > 1) ? $clog2(PAGES) : 1;
	localparam int QW = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
	localparam int CW = $clog2(POOL_DEPTH + 1);
	localparam int SW = $clog2(PAGES + 1);

	pre_pkg::state_t state_q, state_nx;
	pre_pkg::policy_t policy_q;
	logic [6:0]  pages_in_use_q;

	// Page table memory and pool ring memory.
	pre_pkg::entry_t tbl_mem [PAGES];
	logic [9:0]      pool_mem [POOL_DEPTH];
	logic [PAGES-1:0] valid_q;

	pre_pkg::entry_t rd_q;
	logic [9:0]      pool_rd_q;
	logic [QW-1:0]   head_q;
	logic [CW-1:0]   count_q;
	logic [31:0]     faults_q;

	logic [0:0]  mode_q;
	logic [5:0]  page_q;
	logic [31:0] ts_q;
	logic [9:0]  nf_q;

	logic [SW-1:0] scan_q;      // next address issued
	logic [PW-1:0] cand_q;      // address of the row now in rd_q
	logic          cand_v_q;
	logic          found_q;
	logic [PW-1:0] best_idx_q;
	pre_pkg::entry_t best_q;

	logic [2:0]  st_q;
	logic [9:0]  fr_q;
	logic [5:0]  vic_q;

	logic [SW-1:0] limit;
	logic          rd_en;
	logic [PW-1:0] rd_addr;
	logic          wr_en;
	logic [PW-1:0] wr_addr;
	pre_pkg::entry_t wr_data;
	logic          better;
	logic          accept;
	logic          page_ok;
	logic [PW-1:0] pg_idx;

	assign accept  = in_valid && !in_stall;
	assign in_stall = (state_q != pre_pkg::S_IDLE);
	assign out_valid = (state_q == pre_pkg::S_DONE);
	assign status = st_q;
	assign frame = fr_q;
	assign victim_page = vic_q;
	assign fault_total = faults_q;
	assign page_ok = ({26'd0, page_q} < 32'(PAGES));
	assign pg_idx = PW'(page_q);

	always_comb begin
		if ({25'd0, pages_in_use_q} < 32'(PAGES))
			limit = SW'(pages_in_use_q);
		else
			limit = SW'(PAGES);
	end

	pre_victim_cmp u_cmp (
		.policy (policy_q),
		.cand   (rd_q),
		.best   (best_q),
		.better (better)
	);

	// Next state.
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			pre_pkg::S_IDLE: if (accept) state_nx = pre_pkg::S_LOOK;
			pre_pkg::S_LOOK: begin
				if (mode_q == 1'b0 && page_ok && !valid_q[pg_idx] && count_q == '0)
					state_nx = pre_pkg::S_SCAN;
				else
					state_nx = pre_pkg::S_DONE;
			end
			pre_pkg::S_SCAN: if (scan_q >= limit) state_nx = pre_pkg::S_SCAN_LAST;
			pre_pkg::S_SCAN_LAST: state_nx = found_q || (cand_v_q && valid_q[cand_q]) ?
				pre_pkg::S_EVICT : pre_pkg::S_DONE;
			pre_pkg::S_EVICT: state_nx = pre_pkg::S_DONE;
			pre_pkg::S_DONE: if (!out_stall) state_nx = pre_pkg::S_IDLE;
			default: state_nx = pre_pkg::S_IDLE;
		endcase
	end

	// Memory port controls.
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = PW'(page);
		wr_en   = 1'b0;
		wr_addr = pg_idx;
		wr_data = rd_q;
		unique case (state_q)
			pre_pkg::S_IDLE: rd_en = accept;
			pre_pkg::S_LOOK: begin
				if (mode_q == 1'b0 && page_ok) begin
					if (valid_q[pg_idx]) begin
						wr_en = 1'b1;
						wr_data.last_access = ts_q;
						if (rd_q.refs != 16'hFFFF) wr_data.refs = rd_q.refs + 16'd1;
					end else if (count_q != '0) begin
						wr_en = 1'b1;
						wr_data = '{frame: pool_rd_q, arrival: ts_q,
							last_access: ts_q, refs: 16'd1};
					end
				end
				rd_en = 1'b1;
				rd_addr = '0;
			end
			pre_pkg::S_SCAN: begin
				rd_en = 1'b1;
				rd_addr = scan_q[PW-1:0];
			end
			pre_pkg::S_EVICT: begin
				wr_en = 1'b1;
				wr_data = '{frame: best_q.frame, arrival: ts_q,
					last_access: ts_q, refs: 16'd1};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) tbl_mem[wr_addr] <= wr_data;
		if (rd_en) rd_q <= tbl_mem[rd_addr];
	end

	// Pool ring: write at tail, read head.
	logic [QW-1:0] tail;
	always_comb begin
		if (32'(head_q) + 32'(count_q) >= 32'(POOL_DEPTH))
			tail = QW'(32'(head_q) + 32'(count_q) - 32'(POOL_DEPTH));
		else
			tail = QW'(32'(head_q) + 32'(count_q));
	end

	always_ff @(posedge clk) begin
		if (state_q == pre_pkg::S_LOOK && mode_q == 1'b1 && 32'(count_q) < 32'(POOL_DEPTH))
			pool_mem[tail] <= nf_q;
		pool_rd_q <= pool_mem[head_q];
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q <= mode;
			page_q <= page;
			ts_q   <= timestamp;
			nf_q   <= new_frame;
		end
		if (state_q == pre_pkg::S_SCAN_LAST || state_q == pre_pkg::S_SCAN) begin
			if (cand_v_q && valid_q[cand_q] && (!found_q || better)) begin
				best_q     <= rd_q;
				best_idx_q <= cand_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= pre_pkg::S_IDLE;
			policy_q       <= pre_pkg::POL_FIFO;
			pages_in_use_q <= 7'd64;
			valid_q        <= '0;
			head_q         <= '0;
			count_q        <= '0;
			faults_q       <= '0;
			scan_q         <= '0;
			cand_q         <= '0;
			cand_v_q       <= 1'b0;
			found_q        <= 1'b0;
			st_q           <= '0;
			fr_q           <= '0;
			vic_q          <= '0;
		end else begin
			state_q <= state_nx;
			if (cfg_we) begin
				if (cfg_index == pre_pkg::REG_POLICY)
					policy_q <= pre_pkg::policy_t'(cfg_data[1:0]);
				else
					pages_in_use_q <= cfg_data;
			end
			unique case (state_q)
				pre_pkg::S_LOOK: begin
					fr_q  <= '0;
					vic_q <= '0;
					scan_q   <= '0;
					cand_v_q <= 1'b0;
					found_q  <= 1'b0;
					if (mode_q == 1'b1) begin
						if (32'(count_q) < 32'(POOL_DEPTH)) begin
							count_q <= count_q + CW'(1);
							st_q <= pre_pkg::ST_ADDED;
							fr_q <= nf_q;
						end else begin
							st_q <= pre_pkg::ST_FULL;
						end
					end else if (!page_ok) begin
						st_q <= pre_pkg::ST_NONE;
					end else if (valid_q[pg_idx]) begin
						st_q <= pre_pkg::ST_HIT;
						fr_q <= rd_q.frame;
					end else begin
						if (faults_q != 32'hFFFF_FFFF) faults_q <= faults_q + 32'd1;
						if (count_q != '0) begin
							st_q <= pre_pkg::ST_POOL;
							fr_q <= pool_rd_q;
							valid_q[pg_idx] <= 1'b1;
							count_q <= count_q - CW'(1);
							head_q <= (32'(head_q) == POOL_DEPTH - 1) ? '0 : head_q + QW'(1);
						end else begin
							st_q <= pre_pkg::ST_NONE;
						end
					end
				end
				pre_pkg::S_SCAN, pre_pkg::S_SCAN_LAST: begin
					if (cand_v_q && valid_q[cand_q] && (!found_q || better))
						found_q <= 1'b1;
					// rd_q holds row scan_q-1 in S_SCAN after first issue
					cand_q   <= scan_q[PW-1:0];
					cand_v_q <= (state_q == pre_pkg::S_SCAN) && (scan_q < limit);
					if (state_q == pre_pkg::S_SCAN && scan_q < limit)
						scan_q <= scan_q + SW'(1);
				end
				pre_pkg::S_EVICT: begin
					st_q  <= pre_pkg::ST_EVICT;
					fr_q  <= best_q.frame;
					vic_q <= 6'(best_idx_q);
					valid_q[best_idx_q] <= 1'b0;
					valid_q[pg_idx] <= 1'b1;
				end
				default: ;
			endcase
		end
	end

`ifndef ASSERT_OFF
	a_stall_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input taken while a result is pending");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) && $stable(frame))
		else $error("stalled result changed");
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		32'(count_q) <= 32'(POOL_DEPTH))
		else $error("pool count overflow");
	a_evict_found: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == pre_pkg::S_EVICT |-> valid_q[best_idx_q])
		else $error("evicting an invalid entry");
`endif

endmodule

[verif/testbench.sv]
// Testbench for the page replacement engine: directed table, random phases, predictor.
`timescale 1ns / 100ps

module testbench;
	import pre_pkg::*;

	localparam int NPAGES = 64;
	localparam int POOL_MAX = 64;

	typedef struct {
		status_t     st;
		logic [9:0]  fr;
		logic [5:0]  vic;
		logic [31:0] faults;
	} outcome_t;

	typedef struct {
		logic        m;
		logic [5:0]  pg;
		logic [31:0] ts;
		logic [9:0]  nf;
		bit          typed;
		outcome_t    want;
	} row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [0:0]  mode = '0;
	logic [5:0]  page = '0;
	logic [31:0] timestamp = '0;
	logic [9:0]  new_frame = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [2:0]  status;
	logic [9:0]  frame;
	logic [5:0]  victim_page;
	logic [31:0] fault_total;
	logic        cfg_we = 1'b0;
	logic [0:0]  cfg_index = '0;
	logic [6:0]  cfg_data = '0;

	page_replacement_engine dut (.*);

	// predictor copy of the engine
	policy_t     cur_policy;
	logic [6:0]  cur_pages;
	bit          pt_valid [NPAGES];
	logic [9:0]  pt_frame [NPAGES];
	logic [31:0] pt_arrival [NPAGES];
	logic [31:0] pt_last [NPAGES];
	logic [15:0] pt_refs [NPAGES];
	logic [9:0]  free_frames [$];
	logic [31:0] fault_count;

	outcome_t pending [$];
	int errors = 0;
	int n_items = 0;
	int n_status [6];
	bit calm = 0;
	logic [31:0] clock_ts = 0;

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#10ms;
		$display("Verification failed");
		$finish;
	end

	function automatic outcome_t model_item(logic m, logic [5:0] pg, logic [31:0] ts,
			logic [9:0] nf);
		outcome_t r;
		int lim;
		int best;
		bit found;
		bit better;
		r.st = ST_NONE;
		r.fr = '0;
		r.vic = '0;
		if (m) begin
			if (free_frames.size() < POOL_MAX) begin
				free_frames.push_back(nf);
				r.st = ST_ADDED;
				r.fr = nf;
			end else
				r.st = ST_FULL;
		end else if (pt_valid[pg]) begin
			pt_last[pg] = ts;
			if (pt_refs[pg] != 16'hFFFF)
				pt_refs[pg]++;
			r.st = ST_HIT;
			r.fr = pt_frame[pg];
		end else begin
			if (fault_count != 32'hFFFF_FFFF)
				fault_count++;
			if (free_frames.size() > 0) begin
				r.fr = free_frames.pop_front();
				r.st = ST_POOL;
			end else begin
				lim = (cur_pages < NPAGES) ? cur_pages : NPAGES;
				found = 0;
				best = 0;
				for (int i = 0; i < lim; i++) begin
					if (!pt_valid[i])
						continue;
					if (!found)
						better = 1;
					else if (cur_policy == POL_LRU)
						better = pt_last[i] < pt_last[best];
					else if (cur_policy == POL_LFU)
						better = pt_refs[i] < pt_refs[best] ||
							(pt_refs[i] == pt_refs[best] &&
							pt_arrival[i] < pt_arrival[best]);
					else
						better = pt_arrival[i] < pt_arrival[best];
					if (better) begin
						best = i;
						found = 1;
					end
				end
				if (found) begin
					r.fr = pt_frame[best];
					pt_valid[best] = 0;
					r.vic = best[5:0];
					r.st = ST_EVICT;
				end
			end
			if (r.st != ST_NONE) begin
				pt_valid[pg] = 1;
				pt_frame[pg] = r.fr;
				pt_arrival[pg] = ts;
				pt_last[pg] = ts;
				pt_refs[pg] = 16'd1;
			end
		end
		r.faults = fault_count;
		return r;
	endfunction

	task automatic send_item(logic m, logic [5:0] pg, logic [31:0] ts, logic [9:0] nf,
			bit typed, outcome_t want);
		int gap;
		outcome_t got;
		gap = calm ? 0 : $urandom_range(0, 14);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= m;
		page <= pg;
		timestamp <= ts;
		new_frame <= nf;
		do @(posedge clk); while (in_stall);
		got = model_item(m, pg, ts, nf);
		pending.push_back(typed ? want : got);
		n_items++;
		n_status[got.st]++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending.size() != 0)
			@(posedge clk);
		// idle stretch before the next phase
		repeat (80) @(posedge clk);
	endtask

	task automatic write_reg(logic [0:0] idx, logic [6:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		if (idx == REG_POLICY)
			cur_policy = policy_t'(val[1:0]);
		else
			cur_pages = val;
	endtask

	// results side: random stall per item, compare against oldest expectation
	initial begin
		outcome_t e;
		int hold;
		forever begin
			hold = calm ? 0 : $urandom_range(0, 14);
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
				out_stall <= 1'b0;
			end
			do @(posedge clk); while (!out_valid);
			if (pending.size() == 0) begin
				$error("unexpected item: status %0d frame %0d", status, frame);
				errors++;
			end else begin
				e = pending.pop_front();
				if (status !== e.st) begin
					$error("status: expected %0d, got %0d", e.st, status);
					errors++;
				end
				if (frame !== e.fr) begin
					$error("frame: expected %0d, got %0d", e.fr, frame);
					errors++;
				end
				if (victim_page !== e.vic) begin
					$error("victim_page: expected %0d, got %0d", e.vic, victim_page);
					errors++;
				end
				if (fault_total !== e.faults) begin
					$error("fault_total: expected %0d, got %0d", e.faults, fault_total);
					errors++;
				end
			end
		end
	end

	task automatic random_phase(int count, int add_pct, int page_span);
		logic        m;
		logic [5:0]  pg;
		logic [31:0] ts;
		outcome_t    none;
		none = '{ST_HIT, '0, '0, '0};
		for (int k = 0; k < count; k++) begin
			if (k % 40 == 0)
				calm = ($urandom_range(0, 3) == 0);
			m = ($urandom_range(0, 99) < add_pct);
			pg = ($urandom_range(0, 1)) ? 6'($urandom) : 6'($urandom_range(0, page_span - 1));
			if ($urandom_range(0, 9) == 0)
				ts = $urandom;
			else begin
				clock_ts += $urandom_range(0, 20);
				ts = clock_ts;
			end
			send_item(m, pg, ts, 10'($urandom), 0, none);
		end
		calm = 0;
	endtask

	initial begin
		row_t dir [$];
		outcome_t none;
		none = '{ST_HIT, '0, '0, '0};
		cur_policy = POL_FIFO;
		cur_pages = 7'd64;
		fault_count = '0;
		foreach (pt_valid[i])
			pt_valid[i] = 0;

		// directed: empty engine, pool extremes, pool faults, hit, fifo eviction
		dir.push_back('{1'b0, 6'd5, 32'd7, 10'd0, 1, '{ST_NONE, 10'd0, 6'd0, 32'd1}});
		dir.push_back('{1'b1, 6'd0, 32'd0, 10'd1023, 1, '{ST_ADDED, 10'd1023, 6'd0, 32'd1}});
		dir.push_back('{1'b1, 6'd63, 32'd0, 10'd0, 1, '{ST_ADDED, 10'd0, 6'd0, 32'd1}});
		dir.push_back('{1'b0, 6'd0, 32'd0, 10'd0, 1, '{ST_POOL, 10'd1023, 6'd0, 32'd2}});
		dir.push_back('{1'b0, 6'd63, 32'hFFFF_FFFF, 10'h3FF, 1,
			'{ST_POOL, 10'd0, 6'd0, 32'd3}});
		dir.push_back('{1'b0, 6'd0, 32'd100, 10'd0, 1, '{ST_HIT, 10'd1023, 6'd0, 32'd3}});
		dir.push_back('{1'b0, 6'd10, 32'd50, 10'd0, 1, '{ST_EVICT, 10'd1023, 6'd0, 32'd4}});
		dir.push_back('{1'b1, 6'd0, 32'd0, 10'h2AA, 0, none});
		dir.push_back('{1'b1, 6'd0, 32'd0, 10'h155, 0, none});
		dir.push_back('{1'b0, 6'd20, 32'd60, 10'd0, 0, none});
		dir.push_back('{1'b0, 6'd21, 32'd60, 10'd0, 0, none});
		dir.push_back('{1'b0, 6'd10, 32'd70, 10'd0, 0, none});
		dir.push_back('{1'b0, 6'd22, 32'd80, 10'd0, 0, none});
		dir.push_back('{1'b0, 6'd23, 32'd90, 10'd0, 0, none});

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (dir[i])
			send_item(dir[i].m, dir[i].pg, dir[i].ts, dir[i].nf, dir[i].typed, dir[i].want);
		drain();

		// pool overflow: fill past the depth
		calm = 1;
		for (int k = 0; k < POOL_MAX + 3; k++)
			send_item(1'b1, 6'd0, 32'd0, 10'($urandom), 0, none);
		calm = 0;
		drain();

		// LRU over the whole table, then LFU, reserved and FIFO over narrow and wide search bounds, then LRU again
		write_reg(REG_POLICY, 7'(POL_LRU));
		random_phase(110, 15, 12);
		drain();
		write_reg(REG_POLICY, 7'(POL_LFU));
		write_reg(REG_PAGES, 7'd1);
		random_phase(70, 15, 4);
		drain();
		write_reg(REG_PAGES, 7'd64);
		random_phase(90, 15, 10);
		drain();
		write_reg(REG_POLICY, 7'(POL_RSVD));
		write_reg(REG_PAGES, 7'd0);
		random_phase(40, 20, 8);
		drain();
		write_reg(REG_PAGES, 7'd127);
		random_phase(60, 15, 16);
		drain();
		write_reg(REG_POLICY, 7'(POL_FIFO));
		write_reg(REG_PAGES, 7'($urandom_range(2, 63)));
		random_phase(90, 15, 20);
		drain();
		write_reg(REG_POLICY, 7'(POL_LRU));
		write_reg(REG_PAGES, 7'd64);
		random_phase(60, 10, 64);
		drain();

		$display("Ran %0d items over all policies and search bounds 0, 1, 64, 127.",
			n_items);
		$display("hit %0d, pool fault %0d, evict %0d, no frame %0d, added %0d, full %0d",
			n_status[0], n_status[1], n_status[2], n_status[3], n_status[4], n_status[5]);
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

[sim.f]
hw/rtl/pre_pkg.sv
hw/rtl/pre_victim_cmp.sv
hw/rtl/page_replacement_engine.sv
verif/testbench.sv
